### rtl/adu_pkg.sv
// shared types, constants and helper functions for the adam parameter update block
// binary32 field helpers, unit latencies, configuration indexes
// no dependencies
package adu_pkg;

    localparam int RAW_W       = 48;
    localparam int LAT_MUL     = 4;
    localparam int LAT_ADD     = 6;
    localparam int LAT_DIV     = 31;
    localparam int LAT_SQRT    = 30;
    localparam int DIV_STEPS   = 27;
    localparam int SQRT_STEPS  = 26;
    localparam int STEP_BITS   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd4;

    localparam logic [31:0] FP_ONE   = 32'h3F800000;
    localparam logic [31:0] FP_QNAN  = 32'h7FC00000;
    localparam logic [31:0] RST_LR   = 32'h3A83126F;
    localparam logic [31:0] RST_B1   = 32'h3F666666;
    localparam logic [31:0] RST_B2   = 32'h3F7FBE77;
    localparam logic [31:0] RST_EPS  = 32'h322BCC77;
    localparam logic [15:0] RST_STEP = 16'd1;

    typedef logic signed [10:0] t_exp;

    // unrounded result: mant[RAW_W-1] has weight 2^(exp-127)
    typedef struct packed {
        logic             nan;
        logic             inf;
        logic             zero;
        logic             sign;
        t_exp             exp;
        logic [RAW_W-1:0] mant;
        logic             sticky;
    } t_raw;

    typedef struct packed {
        logic [31:0] lr;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] eps;
        logic [31:0] omb1;
        logic [31:0] omb2;
        logic [31:0] c1;
        logic [31:0] c2;
    } t_coef;

    function automatic logic [5:0] lzc48(input logic [47:0] x);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (x[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] fp_mant(input logic [31:0] x);
        return {x[30:23] != 8'd0, x[22:0]};
    endfunction

    function automatic logic [7:0] fp_exp(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    endfunction

endpackage

### rtl/adam_parameter_update.sv
// adam parameter update, binary32 pipeline: one item per cycle unless stalled or busy
// latency is the chain multiply, multiply, add, divide, sqrt, add, divide, multiply, add
// the whole pipeline stalls together only when the output register holds an untaken result
// synchronous active-low reset; after reset and after every register write the corrections
// are recomputed, and no item is accepted until that is done
// depends on adu_pkg, adu_delay, adu_fmul, adu_fadd, adu_fdiv, adu_fsqrt, adu_cfg
module adam_parameter_update
    import adu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_param_value,
    input  logic [31:0]           i_grad_value,
    input  logic [31:0]           i_moment_one_in,
    input  logic [31:0]           i_moment_two_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_param_out,
    output logic [31:0]           o_moment_one_out,
    output logic [31:0]           o_moment_two_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int LAT_TOTAL = 3 * LAT_MUL + 3 * LAT_ADD + 2 * LAT_DIV + LAT_SQRT;
    localparam int FLUSH_W   = $clog2(LAT_TOTAL + 1);

    t_coef       w_coef;
    logic        w_busy;
    logic        w_adv;
    logic [0:0]  w_valid_in;
    logic [0:0]  w_valid_out;
    logic        r_valid_q;
    logic [FLUSH_W-1:0] r_flush_cnt;
    logic        r_flush_q;
    logic [31:0] w_bm;
    logic [31:0] w_og;
    logic [31:0] w_bv;
    logic [31:0] w_o2g;
    logic [31:0] w_g_d;
    logic [31:0] w_bv_d;
    logic [31:0] w_m_new;
    logic [31:0] w_m_new_d;
    logic [31:0] w_gg;
    logic [31:0] w_v_new;
    logic [31:0] w_m_hat;
    logic [31:0] w_m_hat_d;
    logic [31:0] w_v_hat;
    logic [31:0] w_root;
    logic [31:0] w_denom;
    logic [31:0] w_quot;
    logic [31:0] w_stepv;
    logic [31:0] w_p_d;

    adu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coef  (w_coef),
        .o_busy  (w_busy)
    );

    assign w_adv         = !o_out_valid || i_out_ready;
    assign o_in_ready    = w_adv && !w_busy;
    assign w_valid_in[0] = i_in_valid && o_in_ready;

    // valid bit of each stage; stale contents after reset are masked by the flush below
    adu_delay #(.WIDTH(1), .DEPTH(LAT_TOTAL - 1)) u_valid (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (w_valid_in),
        .o_data (w_valid_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_q <= 1'b0;
        end else if (w_adv) begin
            r_valid_q <= w_valid_out[0] && !r_flush_q;
        end
    end

    // lines inside the valid delay hold junk right after reset; mask them until flushed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_cnt <= '0;
            r_flush_q   <= 1'b1;
        end else if (w_adv && r_flush_q) begin
            r_flush_cnt <= r_flush_cnt + 1'b1;
            if (r_flush_cnt == FLUSH_W'(LAT_TOTAL - 2)) r_flush_q <= 1'b0;
        end
    end

    assign o_out_valid = r_valid_q;

    adu_fmul u_mul_bm  (.i_clk(i_clk), .i_en(w_adv), .i_a(w_coef.b1),   .i_b(i_moment_one_in),
                        .o_res(w_bm));
    adu_fmul u_mul_og  (.i_clk(i_clk), .i_en(w_adv), .i_a(w_coef.omb1), .i_b(i_grad_value),
                        .o_res(w_og));
    adu_fmul u_mul_bv  (.i_clk(i_clk), .i_en(w_adv), .i_a(w_coef.b2),   .i_b(i_moment_two_in),
                        .o_res(w_bv));
    adu_fmul u_mul_o2g (.i_clk(i_clk), .i_en(w_adv), .i_a(w_coef.omb2), .i_b(i_grad_value),
                        .o_res(w_o2g));

    adu_delay #(.WIDTH(32), .DEPTH(LAT_MUL)) u_dly_g (
        .i_clk(i_clk), .i_en(w_adv), .i_data(i_grad_value), .o_data(w_g_d));

    adu_fadd u_add_m (.i_clk(i_clk), .i_en(w_adv), .i_a(w_bm), .i_b(w_og), .o_res(w_m_new));

    adu_fmul u_mul_gg (.i_clk(i_clk), .i_en(w_adv), .i_a(w_o2g), .i_b(w_g_d), .o_res(w_gg));

    adu_delay #(.WIDTH(32), .DEPTH(LAT_MUL)) u_dly_bv (
        .i_clk(i_clk), .i_en(w_adv), .i_data(w_bv), .o_data(w_bv_d));

    adu_fadd u_add_v (.i_clk(i_clk), .i_en(w_adv), .i_a(w_bv_d), .i_b(w_gg), .o_res(w_v_new));

    adu_delay #(.WIDTH(32), .DEPTH(LAT_MUL)) u_dly_mn (
        .i_clk(i_clk), .i_en(w_adv), .i_data(w_m_new), .o_data(w_m_new_d));

    adu_fdiv u_div_m (.i_clk(i_clk), .i_en(w_adv), .i_a(w_m_new_d), .i_b(w_coef.c1),
                      .o_res(w_m_hat));
    adu_fdiv u_div_v (.i_clk(i_clk), .i_en(w_adv), .i_a(w_v_new), .i_b(w_coef.c2),
                      .o_res(w_v_hat));

    adu_fsqrt u_sqrt (.i_clk(i_clk), .i_en(w_adv), .i_a(w_v_hat), .o_res(w_root));

    adu_delay #(.WIDTH(32), .DEPTH(LAT_SQRT + LAT_ADD)) u_dly_mh (
        .i_clk(i_clk), .i_en(w_adv), .i_data(w_m_hat), .o_data(w_m_hat_d));

    adu_fadd u_add_den (.i_clk(i_clk), .i_en(w_adv), .i_a(w_root), .i_b(w_coef.eps),
                        .o_res(w_denom));

    adu_fdiv u_div_q (.i_clk(i_clk), .i_en(w_adv), .i_a(w_m_hat_d), .i_b(w_denom),
                      .o_res(w_quot));

    adu_fmul u_mul_step (.i_clk(i_clk), .i_en(w_adv), .i_a(w_coef.lr), .i_b(w_quot),
                         .o_res(w_stepv));

    adu_delay #(.WIDTH(32), .DEPTH(LAT_TOTAL - LAT_ADD)) u_dly_p (
        .i_clk(i_clk), .i_en(w_adv), .i_data(i_param_value), .o_data(w_p_d));

    // subtraction as addition of the negated step
    adu_fadd u_add_p (.i_clk(i_clk), .i_en(w_adv), .i_a(w_p_d),
                      .i_b({~w_stepv[31], w_stepv[30:0]}), .o_res(o_param_out));

    adu_delay #(.WIDTH(32), .DEPTH(LAT_TOTAL - LAT_MUL - LAT_ADD)) u_dly_mo (
        .i_clk(i_clk), .i_en(w_adv), .i_data(w_m_new), .o_data(o_moment_one_out));

    adu_delay #(.WIDTH(32), .DEPTH(LAT_TOTAL - 2 * LAT_MUL - LAT_ADD)) u_dly_vo (
        .i_clk(i_clk), .i_en(w_adv), .i_data(w_v_new), .o_data(o_moment_two_out));
endmodule

### rtl/adu_delay.sv
// shift line that keeps a word aligned with the arithmetic pipeline
// depends on nothing
module adu_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];
endmodule

### rtl/adu_round.sv
// normalize and round-to-nearest-even stage group, three registers deep
// depends on adu_pkg
module adu_round
    import adu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_raw        i_raw,
    output logic [31:0] o_res
);
    t_raw        r1_raw;
    logic [5:0]  r1_lz;
    t_raw        r2_raw;
    t_raw        n2_raw;
    logic [31:0] r_res;
    logic [31:0] n_res;

    logic [25:0] m26;
    logic [25:0] mm;
    logic        st;
    logic [7:0]  ef;
    logic        ovf;
    t_exp        sh;
    logic        inc;
    logic [30:0] packed31;

    always_comb begin
        n2_raw      = r1_raw;
        n2_raw.mant = r1_raw.mant << r1_lz;
        n2_raw.exp  = r1_raw.exp - t_exp'({5'd0, r1_lz});
    end

    always_comb begin
        m26 = r2_raw.mant[RAW_W-1 -: 26];
        st  = (|r2_raw.mant[RAW_W-27:0]) | r2_raw.sticky;
        mm  = m26;
        ef  = 8'd0;
        ovf = 1'b0;
        sh  = t_exp'(1) - r2_raw.exp;
        if (r2_raw.exp > t_exp'(0)) begin
            ovf = r2_raw.exp >= t_exp'(255);
            ef  = r2_raw.exp[7:0];
        end else if (sh >= t_exp'(26)) begin
            mm = 26'd0;
            st = st | (|m26);
        end else begin
            // subnormal: shift right, lost bits fold into sticky
            mm = m26 >> sh[4:0];
            st = st | (m26 != (mm << sh[4:0]));
        end
        inc      = mm[1] & (mm[0] | st | mm[2]);
        packed31 = {ef, mm[24:2]} + 31'(inc);
        if (r2_raw.nan) begin
            n_res = FP_QNAN;
        end else if (r2_raw.inf || ovf) begin
            n_res = {r2_raw.sign, 8'hFF, 23'd0};
        end else if (r2_raw.zero) begin
            n_res = {r2_raw.sign, 31'd0};
        end else begin
            n_res = {r2_raw.sign, packed31};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_raw <= i_raw;
            r1_lz  <= lzc48(i_raw.mant);
            r2_raw <= n2_raw;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

### rtl/adu_fmul.sv
// binary32 multiplier: one product stage followed by the rounding stages
// depends on adu_pkg, adu_round
module adu_fmul
    import adu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res
);
    t_raw r_raw;
    t_raw n_raw;

    always_comb begin
        n_raw.nan    = fp_is_nan(i_a) | fp_is_nan(i_b) |
                       (fp_is_inf(i_a) & fp_is_zero(i_b)) |
                       (fp_is_zero(i_a) & fp_is_inf(i_b));
        n_raw.inf    = fp_is_inf(i_a) | fp_is_inf(i_b);
        n_raw.zero   = fp_is_zero(i_a) | fp_is_zero(i_b);
        n_raw.sign   = i_a[31] ^ i_b[31];
        n_raw.exp    = t_exp'({3'd0, fp_exp(i_a)}) + t_exp'({3'd0, fp_exp(i_b)}) - t_exp'(126);
        n_raw.mant   = fp_mant(i_a) * fp_mant(i_b);
        n_raw.sticky = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_raw <= n_raw;
    end

    adu_round u_round (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_raw (r_raw),
        .o_res (o_res)
    );
endmodule

### rtl/adu_fadd.sv
// binary32 adder: swap, align, add, then the rounding stages
// depends on adu_pkg, adu_round
module adu_fadd
    import adu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res
);
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        sign;
        logic        sub;
        logic [7:0]  ebig;
        logic [7:0]  diff;
        logic [23:0] mbig;
        logic [23:0] msml;
    } t_swap;

    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        sign;
        logic        sub;
        logic [7:0]  ebig;
        logic [47:0] big;
        logic [47:0] sml;
        logic        stk;
    } t_align;

    t_swap       r1;
    t_swap       n1;
    t_align      r2;
    t_align      n2;
    t_raw        r3;
    t_raw        n3;
    logic [31:0] big_w;
    logic [31:0] sml_w;
    logic [47:0] sml_full;
    logic [49:0] sum;

    always_comb begin
        if (i_a[30:0] >= i_b[30:0]) begin
            big_w = i_a;
            sml_w = i_b;
        end else begin
            big_w = i_b;
            sml_w = i_a;
        end
        n1.nan  = fp_is_nan(i_a) | fp_is_nan(i_b) |
                  (fp_is_inf(i_a) & fp_is_inf(i_b) & (i_a[31] != i_b[31]));
        n1.inf  = fp_is_inf(i_a) | fp_is_inf(i_b);
        n1.sign = big_w[31];
        n1.sub  = i_a[31] ^ i_b[31];
        n1.ebig = fp_exp(big_w);
        n1.diff = fp_exp(big_w) - fp_exp(sml_w);
        n1.mbig = fp_mant(big_w);
        n1.msml = fp_mant(sml_w);
    end

    always_comb begin
        sml_full = {r1.msml, 24'd0};
        n2.nan   = r1.nan;
        n2.inf   = r1.inf;
        n2.sign  = r1.sign;
        n2.sub   = r1.sub;
        n2.ebig  = r1.ebig;
        n2.big   = {r1.mbig, 24'd0};
        if (r1.diff >= 8'd48) begin
            n2.sml = 48'd0;
            n2.stk = |r1.msml;
        end else begin
            n2.sml = sml_full >> r1.diff[5:0];
            n2.stk = sml_full != (n2.sml << r1.diff[5:0]);
        end
    end

    always_comb begin
        // sticky rides as the lowest bit so a subtraction rounds correctly
        if (r2.sub) begin
            sum = {1'b0, r2.big, 1'b0} - {1'b0, r2.sml, r2.stk};
        end else begin
            sum = {1'b0, r2.big, 1'b0} + {1'b0, r2.sml, r2.stk};
        end
        n3.nan    = r2.nan;
        n3.inf    = r2.inf;
        n3.zero   = sum == 50'd0;
        n3.sign   = (sum == 50'd0 && !r2.inf) ? (r2.sign & !r2.sub) : r2.sign;
        n3.exp    = t_exp'({3'd0, r2.ebig}) + t_exp'(1);
        n3.mant   = sum[49:2];
        n3.sticky = |sum[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1 <= n1;
            r2 <= n2;
            r3 <= n3;
        end
    end

    adu_round u_round (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_raw (r3),
        .o_res (o_res)
    );
endmodule

### rtl/adu_fdiv.sv
// binary32 divider: restoring division, one quotient bit per stage
// depends on adu_pkg, adu_round
module adu_fdiv
    import adu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res
);
    typedef struct packed {
        logic                 nan;
        logic                 inf;
        logic                 zero;
        logic                 sign;
        t_exp                 exp;
        logic [24:0]          rem;
        logic [23:0]          dvs;
        logic [DIV_STEPS-1:0] q;
    } t_div_st;

    t_div_st     r_st [DIV_STEPS+1];
    t_div_st     n_st [DIV_STEPS+1];
    t_raw        w_raw;
    logic [5:0]  lza;
    logic [5:0]  lzb;
    logic [23:0] ma;
    logic [23:0] mb;

    always_comb begin
        lza = lzc48({fp_mant(i_a), 24'd0});
        lzb = lzc48({fp_mant(i_b), 24'd0});
        ma  = fp_mant(i_a) << lza;
        mb  = fp_mant(i_b) << lzb;
        n_st[0].nan  = fp_is_nan(i_a) | fp_is_nan(i_b) |
                       (fp_is_zero(i_a) & fp_is_zero(i_b)) |
                       (fp_is_inf(i_a) & fp_is_inf(i_b));
        n_st[0].inf  = fp_is_inf(i_a) | fp_is_zero(i_b);
        n_st[0].zero = fp_is_zero(i_a) | fp_is_inf(i_b);
        n_st[0].sign = i_a[31] ^ i_b[31];
        n_st[0].exp  = t_exp'({3'd0, fp_exp(i_a)}) - t_exp'({5'd0, lza}) -
                       t_exp'({3'd0, fp_exp(i_b)}) + t_exp'({5'd0, lzb}) + t_exp'(127);
        n_st[0].rem  = {1'b0, ma};
        n_st[0].dvs  = mb;
        n_st[0].q    = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_st[k+1] = r_st[k];
            if (r_st[k].rem >= {1'b0, r_st[k].dvs}) begin
                n_st[k+1].rem = (r_st[k].rem - {1'b0, r_st[k].dvs}) << 1;
                n_st[k+1].q   = {r_st[k].q[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_st[k+1].rem = r_st[k].rem << 1;
                n_st[k+1].q   = {r_st[k].q[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        w_raw.nan    = r_st[DIV_STEPS].nan;
        w_raw.inf    = r_st[DIV_STEPS].inf;
        w_raw.zero   = r_st[DIV_STEPS].zero;
        w_raw.sign   = r_st[DIV_STEPS].sign;
        w_raw.exp    = r_st[DIV_STEPS].exp;
        w_raw.mant   = {r_st[DIV_STEPS].q, (RAW_W-DIV_STEPS)'(0)};
        w_raw.sticky = r_st[DIV_STEPS].rem != 25'd0;
    end

    adu_round u_round (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_raw (w_raw),
        .o_res (o_res)
    );
endmodule

### rtl/adu_fsqrt.sv
// binary32 square root: digit-by-digit root, one bit per stage
// depends on adu_pkg, adu_round
module adu_fsqrt
    import adu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    output logic [31:0] o_res
);
    localparam int RAD_W = 2 * SQRT_STEPS;
    localparam int REM_W = SQRT_STEPS + 2;

    typedef struct packed {
        logic                  nan;
        logic                  inf;
        logic                  zero;
        logic                  sign;
        t_exp                  exp;
        logic [RAD_W-1:0]      rad;
        logic [REM_W-1:0]      rem;
        logic [SQRT_STEPS-1:0] root;
    } t_sqrt_st;

    t_sqrt_st    r_st [SQRT_STEPS+1];
    t_sqrt_st    n_st [SQRT_STEPS+1];
    t_raw        w_raw;
    logic [5:0]  lz;
    logic [23:0] mn;
    t_exp        e;
    t_exp        e_even;
    logic [24:0] madj;
    logic [REM_W+1:0] rem4 [SQRT_STEPS];
    logic [REM_W+1:0] trial [SQRT_STEPS];

    always_comb begin
        lz     = lzc48({fp_mant(i_a), 24'd0});
        mn     = fp_mant(i_a) << lz;
        e      = t_exp'({3'd0, fp_exp(i_a)}) - t_exp'({5'd0, lz}) - t_exp'(127);
        // odd exponent: move one factor of two into the radicand
        e_even = e[0] ? (e - t_exp'(1)) : e;
        madj   = e[0] ? {mn, 1'b0} : {1'b0, mn};
        n_st[0].zero = fp_is_zero(i_a);
        n_st[0].nan  = fp_is_nan(i_a) | (i_a[31] & !fp_is_zero(i_a));
        n_st[0].inf  = fp_is_inf(i_a);
        n_st[0].sign = i_a[31];
        n_st[0].exp  = (e_even >>> 1) + t_exp'(127);
        n_st[0].rad  = {madj, (RAD_W-25)'(0)};
        n_st[0].rem  = '0;
        n_st[0].root = '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            n_st[k+1]  = r_st[k];
            rem4[k]    = {r_st[k].rem, r_st[k].rad[RAD_W-1 -: 2]};
            trial[k]   = (REM_W+2)'({r_st[k].root, 2'b01});
            n_st[k+1].rad = r_st[k].rad << 2;
            if (rem4[k] >= trial[k]) begin
                n_st[k+1].rem  = REM_W'(rem4[k] - trial[k]);
                n_st[k+1].root = {r_st[k].root[SQRT_STEPS-2:0], 1'b1};
            end else begin
                n_st[k+1].rem  = REM_W'(rem4[k]);
                n_st[k+1].root = {r_st[k].root[SQRT_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        w_raw.nan    = r_st[SQRT_STEPS].nan;
        w_raw.inf    = r_st[SQRT_STEPS].inf;
        w_raw.zero   = r_st[SQRT_STEPS].zero;
        w_raw.sign   = r_st[SQRT_STEPS].sign;
        w_raw.exp    = r_st[SQRT_STEPS].exp;
        w_raw.mant   = {r_st[SQRT_STEPS].root, (RAW_W-SQRT_STEPS)'(0)};
        w_raw.sticky = r_st[SQRT_STEPS].rem != '0;
    end

    adu_round u_round (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_raw (w_raw),
        .o_res (o_res)
    );
endmodule

### rtl/adu_cfg.sv
// config registers and a sequencer that derives bias corrections and 1 - beta
// depends on adu_pkg, adu_fmul, adu_fadd
module adu_cfg
    import adu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_coef                 o_coef,
    output logic                  o_busy
);
    localparam int WAIT_MAX = (LAT_ADD > LAT_MUL) ? LAT_ADD : LAT_MUL;
    localparam int WAIT_W   = $clog2(WAIT_MAX + 1);
    localparam int BIT_W    = $clog2(STEP_BITS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_SUB  = 4'b1000
    } t_seq_state;

    t_seq_state        r_state;
    logic [31:0]       r_lr;
    logic [31:0]       r_b1;
    logic [31:0]       r_b2;
    logic [31:0]       r_eps;
    logic [15:0]       r_step;
    logic              r_sel;
    logic              r_sub;
    logic [BIT_W-1:0]  r_bit;
    logic [WAIT_W-1:0] r_wait;
    logic [15:0]       r_t;
    logic [31:0]       r_acc;
    logic [31:0]       r_base;
    logic [31:0]       r_c1;
    logic [31:0]       r_c2;
    logic [31:0]       r_omb1;
    logic [31:0]       r_omb2;
    logic [31:0]       w_prod_acc;
    logic [31:0]       w_prod_sq;
    logic [31:0]       w_diff;
    logic [31:0]       w_sub_b;
    logic [31:0]       w_beta;
    logic              w_cfg_hit;

    assign w_beta    = r_sel ? r_b2 : r_b1;
    assign w_sub_b   = r_sub ? {~w_beta[31], w_beta[30:0]} : {~r_acc[31], r_acc[30:0]};
    assign w_cfg_hit = i_we && (i_index <= CFG_STEP);

    adu_fmul u_mul_acc (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (r_acc),
        .i_b   (r_base),
        .o_res (w_prod_acc)
    );

    adu_fmul u_mul_sq (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (r_base),
        .i_b   (r_base),
        .o_res (w_prod_sq)
    );

    adu_fadd u_sub (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (FP_ONE),
        .i_b   (w_sub_b),
        .o_res (w_diff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= RST_LR;
            r_b1    <= RST_B1;
            r_b2    <= RST_B2;
            r_eps   <= RST_EPS;
            r_step  <= RST_STEP;
            r_state <= ST_LOAD;
            r_sel   <= 1'b0;
            r_sub   <= 1'b0;
            r_bit   <= '0;
            r_wait  <= '0;
        end else if (w_cfg_hit) begin
            case (i_index)
                CFG_LR:    r_lr   <= i_data;
                CFG_BETA1: r_b1   <= i_data;
                CFG_BETA2: r_b2   <= i_data;
                CFG_EPS:   r_eps  <= i_data;
                CFG_STEP:  r_step <= i_data[15:0];
                default:   r_lr   <= r_lr;
            endcase
            r_state <= ST_LOAD;
            r_sel   <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    r_acc   <= FP_ONE;
                    r_base  <= w_beta;
                    r_t     <= (r_step == 16'd0) ? 16'd1 : r_step;
                    r_bit   <= '0;
                    r_wait  <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_wait == WAIT_W'(LAT_MUL)) begin
                        // square-and-multiply from the low bit of the step count
                        if (r_t[0]) r_acc <= w_prod_acc;
                        r_base <= w_prod_sq;
                        r_t    <= r_t >> 1;
                        r_bit  <= r_bit + 1'b1;
                        r_wait <= '0;
                        if (r_bit == BIT_W'(STEP_BITS - 1)) begin
                            r_state <= ST_SUB;
                            r_sub   <= 1'b0;
                        end
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                ST_SUB: begin
                    if (r_wait == WAIT_W'(LAT_ADD)) begin
                        r_wait <= '0;
                        if (!r_sub) begin
                            if (r_sel) r_c2 <= w_diff;
                            else       r_c1 <= w_diff;
                            r_sub <= 1'b1;
                        end else begin
                            if (r_sel) r_omb2 <= w_diff;
                            else       r_omb1 <= w_diff;
                            r_sub <= 1'b0;
                            if (r_sel) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_sel   <= 1'b1;
                                r_state <= ST_LOAD;
                            end
                        end
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                ST_IDLE: r_state <= ST_IDLE;
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_busy      = r_state != ST_IDLE;
    assign o_coef.lr   = r_lr;
    assign o_coef.b1   = r_b1;
    assign o_coef.b2   = r_b2;
    assign o_coef.eps  = r_eps;
    assign o_coef.omb1 = r_omb1;
    assign o_coef.omb2 = r_omb2;
    assign o_coef.c1   = r_c1;
    assign o_coef.c2   = r_c2;
endmodule
